// File: rtl/core/case_insensitive_substring_detect_macros.svh
// ----------------------------------------------------------------------------
// Case-insensitive substring detector: assertion macros
// Shared concurrent assertion forms for the detector RTL.
// ----------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_SUBSTRING_DETECT_MACROS_SVH
`define CASE_INSENSITIVE_SUBSTRING_DETECT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CISD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CISD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/cisd_pkg.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring detector package
// Sizes, register codes, payload types and the letter fold function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cisd_pkg;

   // Window depth in cells
   localparam int MAX_NEEDLE = 16;

   // Field widths
   localparam int UNIT_W = 16;
   localparam int LEN_W  = 5;

   // Needle storage: four units per 64-bit register, sixteen units total
   localparam int UNITS_PER_REG = 4;
   localparam int NUM_CHAR_REGS = 4;
   localparam int NUM_UNITS     = UNITS_PER_REG * NUM_CHAR_REGS;
   localparam int UNIT_IDX_W    = $clog2(NUM_UNITS);

   // Fill counter and compare widths
   localparam int SEEN_W = $clog2(MAX_NEEDLE + 1);
   localparam int CMP_W  = ((SEEN_W > LEN_W) ? SEEN_W : LEN_W) + 1;

   // Register port
   localparam int CSR_DATA_W = 64;
   localparam int NUM_REGS   = 5;
   localparam int REG_IDX_W  = 3;
   localparam int BYTE_OFS_W = 3;
   localparam int CSR_ADDR_W = REG_IDX_W + BYTE_OFS_W;

   // Fold range: only A..Z become lower case
   localparam logic [UNIT_W-1:0] FOLD_LO     = 16'h0041;
   localparam logic [UNIT_W-1:0] FOLD_HI     = 16'h005A;
   localparam logic [UNIT_W-1:0] FOLD_OFFSET = 16'd32;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_NEEDLE_LENGTH = 3'd0,
      REG_CHARS_A       = 3'd1,
      REG_CHARS_B       = 3'd2,
      REG_CHARS_C       = 3'd3,
      REG_CHARS_D       = 3'd4
   } reg_index_type;

   // Needle configuration as seen by the datapath
   typedef struct packed {
      logic [LEN_W-1:0]                  needle_length;
      logic [NUM_UNITS-1:0][UNIT_W-1:0]  needle_units;
   } cfg_type;

   // One result entry
   typedef struct packed {
      logic found;
      logic final_res;
   } rsp_type;

   function automatic logic [UNIT_W-1:0] fold_unit(input logic [UNIT_W-1:0] c);
      logic [UNIT_W-1:0] r;
      r = c;
      if (c >= FOLD_LO && c <= FOLD_HI) begin
         r = c + FOLD_OFFSET;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/cisd_chan_if.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring detector channels
// Valid/ready interfaces for the code unit stream and the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cisd_req_if;
   logic                          valid;
   logic                          ready;
   logic [cisd_pkg::UNIT_W-1:0]   code_unit;
   logic                          end_of_string;

   modport source (output valid, output code_unit, output end_of_string, input ready);
   modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface cisd_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic final_res;

   modport source (output valid, output found, output final_res, input ready);
   modport sink   (input valid, input found, input final_res, output ready);
endinterface

// File: rtl/core/cisd_csr.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring detector register file
// APB-style write/read port holding the needle length and needle units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cisd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cisd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cisd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cisd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output cisd_pkg::cfg_type                 cfg
);

   logic [cisd_pkg::LEN_W-1:0]      length_ff;
   logic [cisd_pkg::LEN_W-1:0]      length_in;
   logic [cisd_pkg::CSR_DATA_W-1:0] chars_ff [cisd_pkg::NUM_CHAR_REGS];
   logic [cisd_pkg::CSR_DATA_W-1:0] chars_in [cisd_pkg::NUM_CHAR_REGS];
   cisd_pkg::reg_index_type         reg_idx;
   logic                            wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = cisd_pkg::reg_index_type'(
                          csr_paddr[cisd_pkg::CSR_ADDR_W-1:cisd_pkg::BYTE_OFS_W]);

   // Decode the write; out-of-range indexes are dropped
   always_comb begin
      length_in = length_ff;
      for (int k = 0; k < cisd_pkg::NUM_CHAR_REGS; k++) begin
         chars_in[k] = chars_ff[k];
      end
      if (wr_en) begin
         unique case (reg_idx)
            cisd_pkg::REG_NEEDLE_LENGTH: length_in   = csr_pwdata[cisd_pkg::LEN_W-1:0];
            cisd_pkg::REG_CHARS_A:       chars_in[0] = csr_pwdata;
            cisd_pkg::REG_CHARS_B:       chars_in[1] = csr_pwdata;
            cisd_pkg::REG_CHARS_C:       chars_in[2] = csr_pwdata;
            cisd_pkg::REG_CHARS_D:       chars_in[3] = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         for (int k = 0; k < cisd_pkg::NUM_CHAR_REGS; k++) begin
            chars_ff[k] <= '0;
         end
      end else begin
         length_ff <= length_in;
         for (int k = 0; k < cisd_pkg::NUM_CHAR_REGS; k++) begin
            chars_ff[k] <= chars_in[k];
         end
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         cisd_pkg::REG_NEEDLE_LENGTH:
            csr_prdata = cisd_pkg::CSR_DATA_W'(length_ff);
         cisd_pkg::REG_CHARS_A: csr_prdata = chars_ff[0];
         cisd_pkg::REG_CHARS_B: csr_prdata = chars_ff[1];
         cisd_pkg::REG_CHARS_C: csr_prdata = chars_ff[2];
         cisd_pkg::REG_CHARS_D: csr_prdata = chars_ff[3];
         default:               csr_prdata = '0;
      endcase
   end

   // Split the registers into needle units
   assign cfg.needle_length = length_ff;
   for (genvar u = 0; u < cisd_pkg::NUM_UNITS; u++) begin : g_units
      assign cfg.needle_units[u] =
         chars_ff[u / cisd_pkg::UNITS_PER_REG]
                 [(u % cisd_pkg::UNITS_PER_REG) * cisd_pkg::UNIT_W +: cisd_pkg::UNIT_W];
   end

endmodule

// File: rtl/core/cisd_cell.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring detector window cell
// Holds one folded code unit, passes it on at each transfer and compares
// the incoming unit against its aligned needle unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cisd_cell (
   input  logic                          clock,
   input  logic                          shift,
   input  logic                          active,
   input  logic [cisd_pkg::UNIT_W-1:0]   needle_unit,
   input  logic [cisd_pkg::UNIT_W-1:0]   unit_in,
   output logic [cisd_pkg::UNIT_W-1:0]   unit_out,
   output logic                          hit
);

   logic [cisd_pkg::UNIT_W-1:0] unit_ff;

   // Advance the window on each accepted unit
   always_ff @(posedge clock) begin
      if (shift) begin
         unit_ff <= unit_in;
      end
   end

   assign unit_out = unit_ff;

   // Cells past the needle length always agree
   assign hit = !active || (unit_in == needle_unit);

endmodule

// File: rtl/core/case_insensitive_substring_detect.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring detector
// Streams UTF-16 code units through a row of window cells and flags when the
// newest units equal the configured needle, ignoring the case of A..Z.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Carries
//  req_ch    in         valid/ready      code_unit, end_of_string
//  rsp_ch    out        valid/ready      found, final_res
//  csr_*     in/out     APB-style        needle length and needle units
//
//  One code unit per clock while the result queue has room; each result is registered in the queue before it leaves.
//  The cell row compares all needle positions in the cycle of the transfer.
//  A two-entry result queue keeps input ready while a result waits.
//  Synchronous active-high reset clears registers, fill count, flag, queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "case_insensitive_substring_detect_macros.svh"

module case_insensitive_substring_detect (
   input  logic                              clock,
   input  logic                              reset,
   cisd_req_if.sink                          req_ch,
   cisd_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cisd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cisd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cisd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   cisd_pkg::cfg_type               cfg;
   logic [cisd_pkg::UNIT_W-1:0]     chain [cisd_pkg::MAX_NEEDLE+1];
   logic [cisd_pkg::MAX_NEEDLE-1:0] hits;
   logic                            push;
   logic                            pop;
   logic [cisd_pkg::SEEN_W-1:0]     seen_ff;
   logic [cisd_pkg::SEEN_W-1:0]     seen_in;
   logic [cisd_pkg::SEEN_W-1:0]     seen_next;
   logic                            found_ff;
   logic                            found_in;
   logic                            found_next;
   logic                            len_ok;
   logic                            match;
   cisd_pkg::rsp_type               slot_ff [2];
   logic                            wr_ptr_ff;
   logic                            rd_ptr_ff;
   logic [1:0]                      count_ff;
   logic [1:0]                      count_in;

   cisd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign push = req_ch.valid && req_ch.ready;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   // Feed the folded unit into the head of the cell row
   assign chain[0] = cisd_pkg::fold_unit(req_ch.code_unit);

   for (genvar i = 0; i < cisd_pkg::MAX_NEEDLE; i++) begin : g_cells
      logic [cisd_pkg::CMP_W-1:0]  pos;
      logic                        active;
      logic [cisd_pkg::UNIT_W-1:0] needle_unit;

      // Cell i holds needle unit (length - 1 - i); units past storage read as zero
      assign pos    = cisd_pkg::CMP_W'(cfg.needle_length) - cisd_pkg::CMP_W'(1)
                      - cisd_pkg::CMP_W'(i);
      assign active = cisd_pkg::CMP_W'(i) < cisd_pkg::CMP_W'(cfg.needle_length);
      assign needle_unit = (pos < cisd_pkg::CMP_W'(cisd_pkg::NUM_UNITS))
         ? cisd_pkg::fold_unit(cfg.needle_units[pos[cisd_pkg::UNIT_IDX_W-1:0]])
         : '0;

      cisd_cell u_cell (
         .clock       (clock),
         .shift       (push),
         .active      (active),
         .needle_unit (needle_unit),
         .unit_in     (chain[i]),
         .unit_out    (chain[i+1]),
         .hit         (hits[i])
      );
   end

   // Saturating fill count after this unit
   assign seen_next = (seen_ff == cisd_pkg::SEEN_W'(cisd_pkg::MAX_NEEDLE))
                      ? seen_ff : seen_ff + cisd_pkg::SEEN_W'(1);

   assign len_ok = (cfg.needle_length != '0) &&
                   (cisd_pkg::CMP_W'(cfg.needle_length) <=
                    cisd_pkg::CMP_W'(cisd_pkg::MAX_NEEDLE));
   assign match  = len_ok && (&hits) &&
                   (cisd_pkg::CMP_W'(seen_next) >= cisd_pkg::CMP_W'(cfg.needle_length));
   assign found_next = found_ff || match;

   // Hold string state; drop it after the last unit
   always_comb begin
      seen_in  = seen_ff;
      found_in = found_ff;
      if (push) begin
         if (req_ch.end_of_string) begin
            seen_in  = '0;
            found_in = 1'b0;
         end else begin
            seen_in  = seen_next;
            found_in = found_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         seen_ff  <= seen_in;
         found_ff <= found_in;
      end
   end

   // Two-entry result queue
   always_comb begin
      count_in = count_ff;
      priority if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{found: found_next, final_res: req_ch.end_of_string};
      end
   end

   assign req_ch.ready     = (count_ff != 2'd2);
   assign rsp_ch.valid     = (count_ff != 2'd0);
   assign rsp_ch.found     = slot_ff[rd_ptr_ff].found;
   assign rsp_ch.final_res = slot_ff[rd_ptr_ff].final_res;

   // Checks
   `CISD_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= 2'd2, "queue overfilled")
   `CISD_ASSERT_NEXT(a_string_clear, clock, reset, push && req_ch.end_of_string, seen_ff == '0 && !found_ff, "string state not cleared")
   `CISD_ASSERT_NEXT(a_found_sticky, clock, reset, push && !req_ch.end_of_string && found_next, found_ff, "found flag lost mid-string")
   `CISD_ASSERT_SAME(a_match_len, clock, reset, match, cfg.needle_length != '0, "match with empty needle")

endmodule

// File: tb/sv/case_insensitive_substring_detect_checker.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring detector: result checker
// Watches the code unit channel and the register port, predicts the found
// flag and end mark for every transfer and compares each result, in order, with them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module case_insensitive_substring_detect_checker
   import cisd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   cisd_req_if                     req_ch,
   cisd_rsp_if                     rsp_ch,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic                    csr_pready,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output int                      mismatch_count,
   output int                      pending_count,
   output int                      strings_matched
);

   // Predicted string state and needle settings
   logic [UNIT_W-1:0] window_q [MAX_NEEDLE];
   int unsigned       fill_count;
   logic              hit_sticky;
   logic [LEN_W-1:0]  needle_len;
   logic [UNIT_W-1:0] needle_q [NUM_UNITS];
   rsp_type           verdict_q [$];

   // Lower-case only the letters A..Z
   function automatic logic [UNIT_W-1:0] lower_letter(input logic [UNIT_W-1:0] u);
      if (u >= FOLD_LO && u <= FOLD_HI) begin
         return u | FOLD_OFFSET;
      end
      return u;
   endfunction

   // Newest needle_len window cells against the folded needle, oldest first
   function automatic logic needle_in_window();
      int k;
      if (needle_len == 0 || needle_len > MAX_NEEDLE || fill_count < needle_len) begin
         return 1'b0;
      end
      for (k = 0; k < needle_len; k++) begin
         if (window_q[needle_len - 1 - k] != lower_letter(needle_q[k])) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void clear_string();
      int k;
      for (k = 0; k < MAX_NEEDLE; k++) begin
         window_q[k] = '0;
      end
      fill_count = 0;
      hit_sticky = 1'b0;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type              want;
      rsp_type              got;
      logic [REG_IDX_W-1:0] idx;
      int                   base;
      int                   k;
      if (reset) begin
         clear_string();
         needle_len = '0;
         for (k = 0; k < NUM_UNITS; k++) begin
            needle_q[k] = '0;
         end
         verdict_q.delete();
      end else begin
         // Register write: unmapped indexes change nothing
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idx = csr_paddr[CSR_ADDR_W-1:BYTE_OFS_W];
            case (idx)
               REG_NEEDLE_LENGTH: begin
                  needle_len = csr_pwdata[LEN_W-1:0];
               end
               REG_CHARS_A, REG_CHARS_B, REG_CHARS_C, REG_CHARS_D: begin
                  base = (int'(idx) - int'(REG_CHARS_A)) * UNITS_PER_REG;
                  for (k = 0; k < UNITS_PER_REG; k++) begin
                     needle_q[base + k] = csr_pwdata[k*UNIT_W +: UNIT_W];
                  end
               end
               default: ;
            endcase
         end

         // Code unit transfer: shift, compare, queue the expected result
         if (req_ch.valid && req_ch.ready) begin
            for (k = MAX_NEEDLE - 1; k > 0; k--) begin
               window_q[k] = window_q[k-1];
            end
            window_q[0] = lower_letter(req_ch.code_unit);
            if (fill_count < MAX_NEEDLE) begin
               fill_count++;
            end
            if (needle_in_window()) begin
               hit_sticky = 1'b1;
            end
            want.found     = hit_sticky;
            want.final_res = req_ch.end_of_string;
            verdict_q.push_back(want);
            if (req_ch.end_of_string) begin
               if (hit_sticky) begin
                  strings_matched++;
               end
               clear_string();
            end
         end

         // Result transfer: compare with the oldest expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.found     = rsp_ch.found;
            got.final_res = rsp_ch.final_res;
            if (verdict_q.size() == 0) begin
               $error("result with no expectation waiting: found %0b final_res %0b",
                      got.found, got.final_res);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               if (got.found !== want.found) begin
                  $error("found: expected %0b, actual %0b", want.found, got.found);
                  mismatch_count++;
               end
               if (got.final_res !== want.final_res) begin
                  $error("final_res: expected %0b, actual %0b",
                         want.final_res, got.final_res);
                  mismatch_count++;
               end
            end
         end
         pending_count = verdict_q.size();
      end
   end

endmodule

// File: tb/sv/case_insensitive_substring_detect_tb.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring detector: testbench top
// Drives strings of code units under a series of needle settings, with
// random idle and stall mixes and one long receiver hold-off; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module case_insensitive_substring_detect_tb;
   import cisd_pkg::*;

   localparam int ITEM_TARGET  = 1950;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRESSURE_PHASE = 5;
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = REG_IDX_W'(NUM_REGS);
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = '1;
   localparam logic [LEN_W-1:0]     LEN_MAX_CODE    = '1;
   localparam logic [UNIT_W-1:0]    CASE_BIT        = FOLD_OFFSET;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cisd_req_if req_ch ();
   cisd_rsp_if rsp_ch ();

   int mismatch_count;
   int pending_count;
   int strings_matched;
   int units_sent;
   int strings_sent;
   int settings_used;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int hold_requests;

   // Needle currently loaded, used to bias the generated text
   logic [UNIT_W-1:0] needle_cur [NUM_UNITS];
   int                needle_len_cur;

   case_insensitive_substring_detect u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   case_insensitive_substring_detect_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .strings_matched (strings_matched)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard stop for a hung run
   initial begin
      #2_000_000;
      $display("FAIL case_insensitive_substring_detect");
      $finish;
   end

   // Result receiver: random stalls, plus a counted hold-off on request
   initial begin : receiver
      int holds_served;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [UNIT_W-1:0] pick_case(input logic [UNIT_W-1:0] u);
      if ((u >= FOLD_LO && u <= FOLD_HI) ||
          (u >= FOLD_LO + FOLD_OFFSET && u <= FOLD_HI + FOLD_OFFSET)) begin
         return $urandom_range(1) ? (u & ~CASE_BIT) : (u | CASE_BIT);
      end
      return u;
   endfunction

   // Text unit: needle units, letters, the neighbors of the fold range, noise
   function automatic logic [UNIT_W-1:0] random_unit();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35 && needle_len_cur >= 1 && needle_len_cur <= MAX_NEEDLE) begin
         return pick_case(needle_cur[$urandom_range(needle_len_cur - 1)]);
      end
      if (pick < 60) begin
         return pick_case(UNIT_W'(FOLD_LO + $urandom_range(25)));
      end
      if (pick < 70) begin
         case ($urandom_range(3))
            0:       return UNIT_W'(FOLD_LO - 1);
            1:       return UNIT_W'(FOLD_HI + 1);
            2:       return UNIT_W'(FOLD_LO + FOLD_OFFSET - 1);
            default: return UNIT_W'(FOLD_HI + FOLD_OFFSET + 1);
         endcase
      end
      return UNIT_W'($urandom);
   endfunction

   // Offer one code unit, idling first at the current rate
   task automatic send_unit(input logic [UNIT_W-1:0] u, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid     <= 1'b0;
         req_ch.code_unit <= UNIT_W'($urandom);
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.code_unit     <= u;
      req_ch.end_of_string <= last;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready)) begin
         @(posedge clock);
      end
      units_sent++;
      if (last) begin
         strings_sent++;
      end
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic wait_results_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   // Setup then access cycle; the register takes the data on the access edge
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, {BYTE_OFS_W{1'b0}}};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pack_units(input logic [UNIT_W-1:0] u0,
      input logic [UNIT_W-1:0] u1, input logic [UNIT_W-1:0] u2,
      input logic [UNIT_W-1:0] u3);
      return {u3, u2, u1, u0};
   endfunction

   task automatic load_needle(input logic [LEN_W-1:0] len);
      needle_len_cur = int'(len);
      csr_write(REG_NEEDLE_LENGTH, CSR_DATA_W'(len));
      csr_write(REG_CHARS_A, pack_units(needle_cur[0], needle_cur[1], needle_cur[2],
                                        needle_cur[3]));
      csr_write(REG_CHARS_B, pack_units(needle_cur[4], needle_cur[5], needle_cur[6],
                                        needle_cur[7]));
      csr_write(REG_CHARS_C, pack_units(needle_cur[8], needle_cur[9], needle_cur[10],
                                        needle_cur[11]));
      csr_write(REG_CHARS_D, pack_units(needle_cur[12], needle_cur[13], needle_cur[14],
                                        needle_cur[15]));
      settings_used++;
   endtask

   // One string: mostly the needle in random case between random text,
   // sometimes damaged or cut short, else plain noise; close marks the end
   task automatic send_string(input bit close);
      logic [UNIT_W-1:0] text [$];
      int lead;
      int k;
      int damage;
      if (needle_len_cur >= 1 && needle_len_cur <= MAX_NEEDLE &&
          $urandom_range(99) < 70) begin
         lead = $urandom_range(3);
         repeat (lead) text.push_back(random_unit());
         for (k = 0; k < needle_len_cur; k++) begin
            text.push_back(pick_case(needle_cur[k]));
         end
         damage = $urandom_range(99);
         if (damage < 15) begin
            k = lead + $urandom_range(needle_len_cur - 1);
            text[k] = text[k] ^ (16'h0001 << $urandom_range(UNIT_W - 1));
         end else if (damage < 25 && needle_len_cur > 1) begin
            void'(text.pop_back());
         end
         repeat ($urandom_range(3)) text.push_back(random_unit());
      end else begin
         repeat ($urandom_range(1, 8)) text.push_back(random_unit());
      end
      for (k = 0; k < text.size(); k++) begin
         send_unit(text[k], close && (k == text.size() - 1));
      end
   endtask

   initial begin : stimulus
      int phase;
      int phase_end;
      int k;
      int r;
      logic [LEN_W-1:0] len;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.code_unit     <= '0;
      req_ch.end_of_string <= 1'b0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      hold_requests  = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      units_sent     = 0;
      strings_sent   = 0;
      settings_used  = 1;
      needle_len_cur = 0;
      for (k = 0; k < NUM_UNITS; k++) begin
         needle_cur[k] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty needle after reset never matches
      send_unit(16'h0041, 1'b1);

      // Needle "aB": match in mixed case, sticky to the end mark
      wait_results_drained();
      csr_write(REG_NEEDLE_LENGTH, 64'd2);
      csr_write(REG_CHARS_A, pack_units(16'h0061, 16'h0042, 16'h0000, 16'h0000));
      settings_used++;
      send_unit(16'h0051, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0062, 1'b0);
      send_unit(16'h007A, 1'b1);
      // String shorter than the needle, then a fresh match after the clear
      send_unit(16'h0061, 1'b1);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0042, 1'b1);

      // Needle changed mid-string: the window keeps '@' and matches "@["
      send_unit(16'h0040, 1'b0);
      wait_results_drained();
      csr_write(REG_CHARS_A, pack_units(16'h0040, 16'h005B, 16'h0000, 16'h0000));
      settings_used++;
      send_unit(16'h005B, 1'b1);
      // Neighbors of the fold range are not folded: "`{" is no match
      send_unit(16'h0060, 1'b0);
      send_unit(16'h007B, 1'b1);

      // Writes to unmapped indexes leave the needle alone
      wait_results_drained();
      csr_write(REG_UNMAPPED_LO, '1);
      csr_write(REG_UNMAPPED_HI, '1);
      send_unit(16'h0040, 1'b0);
      send_unit(16'h005B, 1'b1);

      // One-unit needle at the top code
      wait_results_drained();
      csr_write(REG_NEEDLE_LENGTH, 64'd1);
      csr_write(REG_CHARS_A, '1);
      settings_used++;
      send_unit(16'h0000, 1'b0);
      send_unit(16'hFFFF, 1'b1);

      // Lengths above the window never match, nor does zero
      wait_results_drained();
      csr_write(REG_NEEDLE_LENGTH, CSR_DATA_W'(MAX_NEEDLE + 1));
      settings_used++;
      send_unit(16'hFFFF, 1'b1);
      wait_results_drained();
      csr_write(REG_NEEDLE_LENGTH, '1);
      settings_used++;
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'hFFFF, 1'b1);
      wait_results_drained();
      csr_write(REG_NEEDLE_LENGTH, 64'd0);
      settings_used++;
      send_unit(16'hFFFF, 1'b1);

      // Random phases: a new needle and one of four idle mixes each time
      phase = 0;
      while (units_sent < ITEM_TARGET) begin
         wait_results_drained();
         for (k = 0; k < NUM_UNITS; k++) begin
            needle_cur[k] = (phase == 0) ? '1 : (phase == 1) ? '0 : random_unit();
         end
         case (phase)
            0:       len = LEN_W'(MAX_NEEDLE);
            1:       len = LEN_W'(1);
            2:       len = LEN_W'(0);
            3:       len = LEN_W'(MAX_NEEDLE + 1);
            4:       len = LEN_MAX_CODE;
            default: begin
               r = $urandom_range(99);
               if (r < 12) begin
                  len = LEN_W'(MAX_NEEDLE);
               end else if (r < 18) begin
                  len = LEN_W'($urandom_range(LEN_MAX_CODE));
               end else begin
                  len = LEN_W'($urandom_range(1, 8));
               end
            end
         endcase
         load_needle(len);

         case (phase % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         if (phase == PRESSURE_PHASE) begin
            // Receiver holds off while the sender keeps offering
            send_idle_pct = 0;
            hold_requests++;
         end

         phase_end = units_sent +
                     ((len == 0 || len > MAX_NEEDLE) ? 40 : 150);
         while (units_sent < phase_end && units_sent < ITEM_TARGET) begin
            send_string(1'b1);
         end
         // Sometimes leave a string open across the next needle change
         if ($urandom_range(1)) begin
            send_string(1'b0);
         end
         phase++;
      end

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d code units in %0d strings over %0d needle settings; %0d %s",
               units_sent, strings_sent, settings_used, strings_matched,
               "strings ended with the needle found.");
      $display("Idle mixes: none, sender 81%%, receiver 81%%, both 26%%, and a %0d-cycle %s",
               HOLD_CYCLES, "receiver hold-off.");
      if (mismatch_count == 0) begin
         $display("PASS case_insensitive_substring_detect");
      end else begin
         $display("FAIL case_insensitive_substring_detect");
      end
      $finish;
   end

endmodule
